[rtl/dithered_palette_quantizer_defines.svh]
// ----------------------------------------------------------------------------
// dithered_palette_quantizer_defines.svh
// Assertion macros shared by the quantizer's checkers.
// ----------------------------------------------------------------------------
`ifndef DITHERED_PALETTE_QUANTIZER_DEFINES_SVH
`define DITHERED_PALETTE_QUANTIZER_DEFINES_SVH

// Concurrent assertion, disabled while reset is asserted.
`define DPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define DPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dpq_pkg.sv]
// ----------------------------------------------------------------------------
// dpq_pkg
// Widths, codes and shared types of the dithered palette quantizer.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int PIX_W         = 10;
  localparam int OFF_W         = 7;
  localparam int IDX_W         = 5;
  localparam int COMP_W        = 8;
  localparam int CODE_W        = 5;
  localparam int DEFAULT_ENTRIES = 17;

  // pal + off - pix spans -1087..318
  localparam int DIFF_W = 12;
  // square of a difference stays below 2^21
  localparam int SQ_W   = 21;
  // sum of three squares stays below 2^22
  localparam int ERR_W  = 22;

  localparam logic [ERR_W-1:0] START_ERR = ERR_W'(65536 * 3);

  localparam logic FUNC_QUANT = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  typedef struct packed {
    logic        [PIX_W-1:0] red;
    logic        [PIX_W-1:0] green;
    logic        [PIX_W-1:0] blue;
    logic signed [OFF_W-1:0] offset;
  } pix_t;

  // per-stage advance enables of one lane
  typedef struct packed {
    logic diff;
    logic square;
    logic sum;
  } lane_en_t;

  // error of one entry; hit means it beats the start value
  typedef struct packed {
    logic             hit;
    logic [ERR_W-1:0] err;
  } leaf_t;

endpackage

[rtl/dpq_if.sv]
// ----------------------------------------------------------------------------
// dpq_pix_if / dpq_code_if
// Valid/ready channels of the quantizer: input beats and color codes.
// ----------------------------------------------------------------------------
interface dpq_pix_if import dpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic        [PIX_W-1:0] red;
  logic        [PIX_W-1:0] green;
  logic        [PIX_W-1:0] blue;
  logic signed [OFF_W-1:0] dither_offset;
  logic        [IDX_W-1:0] entry_index;
  logic       [COMP_W-1:0] entry_red;
  logic       [COMP_W-1:0] entry_green;
  logic       [COMP_W-1:0] entry_blue;

  modport source (
    output valid, func, red, green, blue, dither_offset,
           entry_index, entry_red, entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, func, red, green, blue, dither_offset,
           entry_index, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

interface dpq_code_if import dpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] color_code;

  modport source (output valid, color_code, input ready);
  modport sink   (input valid, color_code, output ready);
endinterface

[rtl/dithered_palette_quantizer.sv]
// ----------------------------------------------------------------------------
// dithered_palette_quantizer
// Nearest dithered palette color search over a loadable palette.
// ----------------------------------------------------------------------------
//   channel   dir  beat                                        result
//   in_if     in   func, pixel rgb, dither_offset, load entry   quantize: one code
//                                                               load: none
//   out_if    out  color_code (best entry minus one, 0 if none hits)  -
//
// One beat per cycle while the output is not stalled. A quantize beat passes
// the difference, square and sum registers, one register per tree level and
// the code register. A load writes its lane's entry at the accepting edge and
// holds for every later beat. Reset clears only the stage valids; the palette
// is undefined until loaded. A stall at the output freezes the full stages
// while bubbles still fill.
// ----------------------------------------------------------------------------
module dithered_palette_quantizer import dpq_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  dpq_pix_if.sink    in_if,
  dpq_code_if.source out_if
);

  localparam int LVLS = $clog2(ENTRIES);
  localparam int NST  = LVLS + 4;

  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST-1:0] en_w;
  logic           in_acc;
  logic           wr_en [ENTRIES];
  leaf_t          leaf_w [ENTRIES];
  pix_t           pix_w;
  lane_en_t       lane_en;

  // a stage moves when empty or when the one after it moves
  always_comb begin
    en_w[NST-1] = !vld_r[NST-1] || out_if.ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en_w[s] = !vld_r[s] || en_w[s+1];
    end
  end

  assign in_if.ready = en_w[0];
  assign in_acc      = in_if.valid && en_w[0];

  always_comb begin
    vld_nxt = vld_r;
    if (en_w[0]) begin
      vld_nxt[0] = in_acc && (in_if.func == FUNC_QUANT);
    end
    for (int s = 1; s < NST; s++) begin
      if (en_w[s]) begin
        vld_nxt[s] = vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pix_w = '{red: in_if.red, green: in_if.green, blue: in_if.blue,
                   offset: in_if.dither_offset};

  assign lane_en = '{diff: en_w[0], square: en_w[1], sum: en_w[2]};

  for (genvar k = 0; k < ENTRIES; k++) begin : g_lane
    assign wr_en[k] = in_acc && (in_if.func == FUNC_LOAD) && (int'(in_if.entry_index) == k);

    dpq_lane u_lane (
      .clk     (clk),
      .wr_en   (wr_en[k]),
      .wr_data ({in_if.entry_red, in_if.entry_green, in_if.entry_blue}),
      .pix     (pix_w),
      .en      (lane_en),
      .leaf    (leaf_w[k])
    );
  end

  dpq_min_tree #(.ENTRIES(ENTRIES)) u_tree (
    .clk        (clk),
    .leaf       (leaf_w),
    .tree_en    (en_w[NST-2:3]),
    .out_en     (en_w[NST-1]),
    .color_code (out_if.color_code)
  );

  assign out_if.valid = vld_r[NST-1];

endmodule

[rtl/dpq_lane.sv]
// ----------------------------------------------------------------------------
// dpq_lane
// One palette entry and its three-stage squared-error datapath.
// ----------------------------------------------------------------------------
module dpq_lane import dpq_pkg::*; (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [3*COMP_W-1:0]   wr_data,
  input  pix_t                  pix,
  input  lane_en_t              en,
  output leaf_t                 leaf
);

  logic        [3*COMP_W-1:0] pal_r;
  logic signed [DIFF_W-1:0]   dr_r, dg_r, db_r;
  logic signed [DIFF_W-1:0]   dr_nxt, dg_nxt, db_nxt;
  logic        [SQ_W-1:0]     sr_r, sg_r, sb_r;
  logic        [SQ_W-1:0]     sr_nxt, sg_nxt, sb_nxt;
  leaf_t                      leaf_r, leaf_nxt;

  function automatic logic signed [DIFF_W-1:0] diff(
    input logic        [COMP_W-1:0] comp,
    input logic signed [OFF_W-1:0]  off,
    input logic        [PIX_W-1:0]  px
  );
    logic signed [DIFF_W-1:0] c, o, p;
    c = $signed({{(DIFF_W-COMP_W){1'b0}}, comp});
    o = DIFF_W'(off);
    p = $signed({{(DIFF_W-PIX_W){1'b0}}, px});
    return c + o - p;
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic signed [DIFF_W-1:0] d);
    logic signed [2*DIFF_W-1:0] p;
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  always_comb begin
    dr_nxt = diff(pal_r[3*COMP_W-1:2*COMP_W], pix.offset, pix.red);
    dg_nxt = diff(pal_r[2*COMP_W-1:COMP_W],   pix.offset, pix.green);
    db_nxt = diff(pal_r[COMP_W-1:0],          pix.offset, pix.blue);
    sr_nxt = square(dr_r);
    sg_nxt = square(dg_r);
    sb_nxt = square(db_r);
    leaf_nxt.err = ERR_W'(sr_r) + ERR_W'(sg_r) + ERR_W'(sb_r);
    leaf_nxt.hit = (leaf_nxt.err < START_ERR);
  end

  // palette entry: no reset, undefined until loaded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_r <= wr_data;
    end
    if (en.diff) begin
      dr_r <= dr_nxt;
      dg_r <= dg_nxt;
      db_r <= db_nxt;
    end
    if (en.square) begin
      sr_r <= sr_nxt;
      sg_r <= sg_nxt;
      sb_r <= sb_nxt;
    end
    if (en.sum) begin
      leaf_r <= leaf_nxt;
    end
  end

  assign leaf = leaf_r;

endmodule

[rtl/dpq_min_tree.sv]
// ----------------------------------------------------------------------------
// dpq_min_tree
// Registered pairwise minimum tree over the lane errors, then code register.
// ----------------------------------------------------------------------------
module dpq_min_tree import dpq_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                      clk,
  input  leaf_t                     leaf [ENTRIES],
  input  logic [$clog2(ENTRIES)-1:0] tree_en,
  input  logic                      out_en,
  output logic signed [CODE_W-1:0]  color_code
);

  localparam int LVLS = $clog2(ENTRIES);
  localparam int NPAD = 1 << LVLS;
  localparam int IW   = LVLS;
  localparam int XW   = IW + CODE_W;

  typedef struct packed {
    logic             hit;
    logic [ERR_W-1:0] err;
    logic [IW-1:0]    idx;
  } node_t;

  // heap order: node n has children 2n+1 and 2n+2, leaves follow the nodes
  node_t node_r [NPAD-1];
  node_t kid_w  [2*NPAD-1];

  logic signed [CODE_W-1:0] code_r, code_nxt;
  logic [XW-1:0]            code_ext;

  // right side wins when only it hits or when both hit and it is strictly lower: ties keep the lower entry
  function automatic node_t pick(input node_t a, input node_t b);
    return (b.hit && (!a.hit || (b.err < a.err))) ? b : a;
  endfunction

  for (genvar i = 0; i < NPAD - 1; i++) begin : g_inner
    assign kid_w[i] = node_r[i];
  end

  for (genvar k = 0; k < NPAD; k++) begin : g_leaf
    if (k < ENTRIES) begin : g_real
      assign kid_w[NPAD-1+k] = '{hit: leaf[k].hit, err: leaf[k].err, idx: IW'(k)};
    end else begin : g_pad
      assign kid_w[NPAD-1+k] = '{hit: 1'b0, err: '0, idx: IW'(k)};
    end
  end

  for (genvar n = 0; n < NPAD - 1; n++) begin : g_node
    localparam int DEPTH = $clog2(n + 2) - 1;
    always_ff @(posedge clk) begin
      if (tree_en[LVLS-1-DEPTH]) begin
        node_r[n] <= pick(kid_w[2*n+1], kid_w[2*n+2]);
      end
    end
  end

  always_comb begin
    code_ext = XW'(node_r[0].idx) - XW'(1);
    code_nxt = node_r[0].hit ? $signed(code_ext[CODE_W-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      code_r <= code_nxt;
    end
  end

  assign color_code = code_r;

endmodule

[rtl/dpq_checker.sv]
// ----------------------------------------------------------------------------
// dpq_checker
// Port-level checks of the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dithered_palette_quantizer_defines.svh"

module dpq_checker import dpq_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [CODE_W-1:0] color_code
);

  // input only backs up when the output beat is blocked
  `DPQ_ASSERT(a_in_stall_cause, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "input stalled without output backpressure")

  `DPQ_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "output beat dropped while stalled")

  `DPQ_ASSERT(a_code_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(color_code), "color code changed while stalled")

  `DPQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind dithered_palette_quantizer dpq_checker u_dpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .color_code (out_if.color_code)
);
